// ===== design/lsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_pkg: shared types and constants of the line substring matcher
// Byte and counter widths, configuration register indexes, the pattern
// configuration bundle and the ASCII case fold.
// ----------------------------------------------------------------------------
package lsm_pkg;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 32;
    localparam int PAT_BYTES = 16;
    localparam int CFG_W     = 64;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CASE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_RESULT  = 3'd4;

    localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    // Pattern settings seen by the compare logic
    typedef struct packed {
        logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
        logic [LEN_W-1:0]                 length;
        logic                             ignore_case;
    } pat_cfg_t;

    // Fold ASCII upper case to lower case when enabled
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic en);
        logic [BYTE_W-1:0] r;
        r = b;
        if (en && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
            r = b + CASE_OFFSET;
        return r;
    endfunction

endpackage

// ===== design/lsm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_if: valid/ready channels of the line substring matcher
// Text byte channel into the block and line result channel out of it.
// ----------------------------------------------------------------------------
interface lsm_text_if;
    logic                        valid;
    logic                        ready;
    logic [lsm_pkg::BYTE_W-1:0]  text_byte;
    logic                        file_last;

    modport source (output valid, output text_byte, output file_last, input ready);
    modport sink   (input valid, input text_byte, input file_last, output ready);
endinterface

interface lsm_result_if;
    logic                        valid;
    logic                        ready;
    logic                        line_selected;
    logic [lsm_pkg::COUNT_W-1:0] line_count;
    logic [lsm_pkg::COUNT_W-1:0] selected_total;

    modport source (output valid, output line_selected, output line_count,
                    output selected_total, input ready);
    modport sink   (input valid, input line_selected, input line_count,
                    input selected_total, output ready);
endinterface

// ===== design/lsm_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_match: parallel pattern compare against the recent byte window
// Works out the effective pattern length and checks whether the pattern
// ends at the newest byte of the window.
// ----------------------------------------------------------------------------
module lsm_match #(
    parameter int NPAT = 16
) (
    input  lsm_pkg::pat_cfg_t                       cfg,
    input  logic [NPAT-1:0][lsm_pkg::BYTE_W-1:0]   window,
    output logic                                    hit
);

    logic [lsm_pkg::LEN_W-1:0] lim;
    logic [lsm_pkg::LEN_W-1:0] eff_len;

    // Clamp the length, then cut the pattern at its first zero byte
    always_comb
    begin
        lim = (cfg.length > lsm_pkg::LEN_W'(NPAT)) ? lsm_pkg::LEN_W'(NPAT) : cfg.length;
        eff_len = lim;
        for (int i = lsm_pkg::PAT_BYTES - 1; i >= 0; i--)
        begin
            if (lsm_pkg::LEN_W'(i) < lim && cfg.pattern[i] == lsm_pkg::CHAR_NUL)
                eff_len = lsm_pkg::LEN_W'(i);
        end
    end

    // Pattern byte k lines up with window byte eff_len-1-k (newest first)
    always_comb
    begin
        logic [lsm_pkg::BYTE_W-1:0] sel;
        hit = 1'b1;
        for (int k = 0; k < NPAT; k++)
        begin
            sel = lsm_pkg::CHAR_NUL;
            for (int j = 0; j < NPAT; j++)
            begin
                if (lsm_pkg::LEN_W'(j + k + 1) == eff_len)
                    sel = window[j];
            end
            if (lsm_pkg::LEN_W'(k) < eff_len &&
                lsm_pkg::fold_byte(sel, cfg.ignore_case) !=
                lsm_pkg::fold_byte(cfg.pattern[k], cfg.ignore_case))
                hit = 1'b0;
        end
    end

endmodule

// ===== design/line_substring_matcher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_substring_matcher_core: per-line substring search over a byte stream
// Splits the text into lines and reports, at each line end, whether the
// configured pattern occurred (optionally inverted), the line number and the running selected-line count.
//
// A line's result is loaded into the result register when its last byte
// advances out of the input register.
// Throughput: one byte per cycle; the compare window is checked in parallel.
// A line-end byte waits in the input register while an earlier result is held.
// Reset clears configuration, line state, counters and both valid flags.
// ----------------------------------------------------------------------------
module line_substring_matcher_core #(
    parameter int MAX_PATTERN      = 16,
    parameter int LINE_BUFFER_SIZE = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lsm_text_if.sink                          text,
    lsm_result_if.source                      result,
    input  logic                              write_enable,
    input  logic [lsm_pkg::CFG_IDX_W-1:0]     reg_index,
    input  logic [lsm_pkg::CFG_W-1:0]         write_data
);

    localparam int NPAT  = (MAX_PATTERN < lsm_pkg::PAT_BYTES) ? MAX_PATTERN
                                                               : lsm_pkg::PAT_BYTES;
    localparam int POS_W = $clog2(LINE_BUFFER_SIZE);
    localparam logic [POS_W-1:0] POS_END = POS_W'(LINE_BUFFER_SIZE - 1);
    localparam logic [lsm_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration registers
    logic [lsm_pkg::CFG_W-1:0]  pattern_low_reg;
    logic [lsm_pkg::CFG_W-1:0]  pattern_high_reg;
    logic [lsm_pkg::LEN_W-1:0]  pattern_length_reg;
    logic                       ignore_case_reg;
    logic                       invert_result_reg;

    // Input register
    logic                        s1_valid_reg;
    logic [lsm_pkg::BYTE_W-1:0]  s1_byte_reg;
    logic                        s1_last_reg;

    // Line state
    logic [NPAT-1:0][lsm_pkg::BYTE_W-1:0] win_reg;
    logic [NPAT-1:0][lsm_pkg::BYTE_W-1:0] win_next;
    logic [POS_W-1:0]                     pos_reg;
    logic                                 found_reg;
    logic                                 stopped_reg;
    logic [lsm_pkg::COUNT_W-1:0]          seen_reg;
    logic [lsm_pkg::COUNT_W-1:0]          selected_reg;
    logic [lsm_pkg::COUNT_W-1:0]          seen_next;
    logic [lsm_pkg::COUNT_W-1:0]          selected_next;

    // Result register
    logic                        out_valid_reg;
    logic                        out_sel_reg;
    logic [lsm_pkg::COUNT_W-1:0] out_count_reg;
    logic [lsm_pkg::COUNT_W-1:0] out_total_reg;

    lsm_pkg::pat_cfg_t cfg;
    logic              push;
    logic              hit;
    logic              found_now;
    logic [POS_W-1:0]  pos_inc;
    logic              line_end;
    logic              sel;
    logic              advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            ignore_case_reg    <= 1'b0;
            invert_result_reg  <= 1'b0;
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                lsm_pkg::REG_PATTERN_LOW:    pattern_low_reg    <= write_data;
                lsm_pkg::REG_PATTERN_HIGH:   pattern_high_reg   <= write_data;
                lsm_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= write_data[lsm_pkg::LEN_W-1:0];
                lsm_pkg::REG_IGNORE_CASE:    ignore_case_reg    <= write_data[0];
                lsm_pkg::REG_INVERT_RESULT:  invert_result_reg  <= write_data[0];
                default: ;
            endcase
        end
    end

    assign cfg.pattern     = {pattern_high_reg, pattern_low_reg};
    assign cfg.length      = pattern_length_reg;
    assign cfg.ignore_case = ignore_case_reg;

    // Shift the new byte into the window, newest first
    always_comb
    begin
        win_next[0] = s1_byte_reg;
        for (int i = 1; i < NPAT; i++)
            win_next[i] = win_reg[i-1];
    end

    lsm_match #(
        .NPAT (NPAT)
    ) u_match (
        .cfg    (cfg),
        .window (win_next),
        .hit    (hit)
    );

    // Decide the line end and the selection for the byte in the input register
    assign push      = !stopped_reg && (s1_byte_reg != lsm_pkg::CHAR_NUL);
    assign found_now = found_reg || (push && hit);
    assign pos_inc   = pos_reg + POS_W'(1);
    assign line_end  = (s1_byte_reg == lsm_pkg::CHAR_NEWLINE) || s1_last_reg ||
                       (pos_inc == POS_END);
    assign sel       = found_now ^ invert_result_reg;

    assign seen_next     = (seen_reg == COUNT_MAX) ? seen_reg
                                                   : seen_reg + lsm_pkg::COUNT_W'(1);
    assign selected_next = (sel && selected_reg != COUNT_MAX)
                         ? selected_reg + lsm_pkg::COUNT_W'(1)
                         : selected_reg;

    // A byte that ends no line never waits on the result register
    assign advance    = s1_valid_reg && (!line_end || !out_valid_reg || result.ready);
    assign text.ready = !s1_valid_reg || advance;

    // Hold the accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (text.ready)
            s1_valid_reg <= text.valid;
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            s1_byte_reg <= text.text_byte;
            s1_last_reg <= text.file_last;
        end
    end

    // Advance the line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '0;
            pos_reg      <= '0;
            found_reg    <= 1'b0;
            stopped_reg  <= 1'b0;
            seen_reg     <= '0;
            selected_reg <= '0;
        end
        else if (advance)
        begin
            if (line_end)
            begin
                win_reg      <= '0;
                pos_reg      <= '0;
                found_reg    <= 1'b0;
                stopped_reg  <= 1'b0;
                seen_reg     <= seen_next;
                selected_reg <= selected_next;
            end
            else
            begin
                if (push)
                    win_reg <= win_next;
                pos_reg     <= pos_inc;
                found_reg   <= found_now;
                stopped_reg <= stopped_reg || (s1_byte_reg == lsm_pkg::CHAR_NUL);
            end
        end
    end

    // Load the result register at a line end, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && line_end)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && line_end)
        begin
            out_sel_reg   <= sel;
            out_count_reg <= seen_next;
            out_total_reg <= selected_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.line_selected  = out_sel_reg;
    assign result.line_count     = out_count_reg;
    assign result.selected_total = out_total_reg;

    // Selected lines never outnumber the lines seen
    assert property (@(posedge clk) disable iff (!rst_n)
        selected_reg <= seen_reg)
        else $error("selected count exceeds line count");

    // A line end starts the next line from a clean state
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && line_end |=> pos_reg == '0 && !found_reg && !stopped_reg)
        else $error("line state not cleared at line end");

    // The result carries the updated line counter
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && line_end |=> out_valid_reg && out_count_reg == seen_reg &&
                                out_total_reg == selected_reg)
        else $error("result does not match the counters");

    // After a zero byte the window no longer moves within the line
    assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg && advance && !line_end |=> $stable(win_reg))
        else $error("window moved after search stop");

endmodule

// ===== dv/line_substring_matcher_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_substring_matcher_core_test: self-checking bench for the line matcher
// Streams text bytes into the core and checks each line result against an
// in-bench line predictor or a typed-in expectation. A short table of directed
// bytes and register writes runs first, then randomised phases with fresh
// pattern settings, bursty input and a stalling result receiver.
// ----------------------------------------------------------------------------
module line_substring_matcher_core_test;

    localparam int MAX_PATTERN      = 16;
    localparam int LINE_BUFFER_SIZE = 256;
    localparam int LINE_LIMIT       = LINE_BUFFER_SIZE - 1;
    localparam int DRAIN_CYCLES     = 4;
    localparam int RANDOM_ITEMS     = 550;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int DIRECTED_LEN     = 28;

    typedef enum logic { ROW_TEXT, ROW_WRITE } row_kind_t;

    typedef struct packed {
        logic                        selected;
        logic [lsm_pkg::COUNT_W-1:0] line_no;
        logic [lsm_pkg::COUNT_W-1:0] total;
    } line_result_t;

    typedef struct packed {
        row_kind_t                     kind;
        logic [lsm_pkg::CFG_IDX_W-1:0] reg_idx;   // unused on text rows
        logic [lsm_pkg::CFG_W-1:0]     value;     // text byte in bits 7:0 on text rows
        logic                          last;
        logic                          typed;     // result below is typed in
        line_result_t                  want;
    } stim_row_t;

    // Empty pattern after reset, then a folded two-byte pattern, then a
    // clamped length with a zero byte ending the pattern, then inversion
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'h61, 1'b1, 1'b1, '{1'b1, 32'd1, 32'd1}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'h00, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'h78, 1'b1, 1'b1, '{1'b0, 32'd2, 32'd1}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'h0A, 1'b0, 1'b1, '{1'b1, 32'd3, 32'd2}},
        '{ROW_WRITE, lsm_pkg::REG_PATTERN_LOW,    64'h6241, 1'b0, 1'b0,
          '{1'b0, 32'd0, 32'd0}},
        '{ROW_WRITE, lsm_pkg::REG_PATTERN_LENGTH, 64'd2, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_WRITE, lsm_pkg::REG_IGNORE_CASE,    64'd1, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'h61, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'h42, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'h0A, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'h61, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'h00, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'h62, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'h0A, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_WRITE, lsm_pkg::REG_PATTERN_LOW,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0,
          '{1'b0, 32'd0, 32'd0}},
        '{ROW_WRITE, lsm_pkg::REG_PATTERN_HIGH,   64'h0, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_WRITE, lsm_pkg::REG_PATTERN_LENGTH, 64'd31, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_WRITE, lsm_pkg::REG_IGNORE_CASE,    64'd0, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'hFF, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'hFF, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'hFF, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'hFF, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'hFF, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'hFF, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'hFF, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'hFF, 1'b1, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_WRITE, lsm_pkg::REG_INVERT_RESULT,  64'd1, 1'b0, 1'b0, '{1'b0, 32'd0, 32'd0}},
        '{ROW_TEXT,  lsm_pkg::REG_PATTERN_LOW,    64'h7A, 1'b1, 1'b0, '{1'b0, 32'd0, 32'd0}}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          write_enable;
    logic [lsm_pkg::CFG_IDX_W-1:0] reg_index;
    logic [lsm_pkg::CFG_W-1:0]     write_data;

    lsm_text_if   text_ch ();
    lsm_result_if result_ch ();

    line_substring_matcher_core #(
        .MAX_PATTERN      (MAX_PATTERN),
        .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text         (text_ch),
        .result       (result_ch),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    // Predictor copy of the registers
    logic [lsm_pkg::PAT_BYTES-1:0][lsm_pkg::BYTE_W-1:0] cfg_pattern;
    logic [lsm_pkg::LEN_W-1:0]                          cfg_length;
    logic                                               cfg_fold;
    logic                                               cfg_invert;

    // Predictor copy of the line state
    logic [lsm_pkg::BYTE_W-1:0]  window_bytes [lsm_pkg::PAT_BYTES];
    int                          bytes_in_line;
    bit                          pattern_found;
    bit                          zero_seen;
    logic [lsm_pkg::COUNT_W-1:0] lines_counted;
    logic [lsm_pkg::COUNT_W-1:0] lines_chosen;

    line_result_t pending_line_results [$];
    int           mismatch_count;
    int           cycle_count;
    int           items_sent;
    int           burst_left;
    bit           gaps_on;

    // Typed-in expectation travelling with the byte on the channel
    bit           typed_valid;
    line_result_t typed_line;

    // Receiver stall pattern
    logic [15:0] stall_mask;
    int          stall_step;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hold the run to a cycle budget
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stall the result channel on a mask pattern that is redrawn whenever stall_step wraps to zero
    always @(posedge clk)
    begin
        if (stall_step == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_mask = 16'hFFFF;
                1: stall_mask = 16'($urandom) | 16'h0001;
                2: stall_mask = 16'($urandom & $urandom) | 16'h0001;
                default: stall_mask = 16'h8001;
            endcase
        end
        result_ch.ready <= stall_mask[stall_step % 16];
        stall_step = (stall_step + 1) % 64;
    end

    function automatic logic [lsm_pkg::BYTE_W-1:0] lower_ascii(
        input logic [lsm_pkg::BYTE_W-1:0] b);
        if (cfg_fold && b >= lsm_pkg::CHAR_UPPER_A && b <= lsm_pkg::CHAR_UPPER_Z)
            return b + lsm_pkg::CASE_OFFSET;
        return b;
    endfunction

    // Number of pattern bytes in use: clamped, and cut at a zero byte
    function automatic int pattern_span();
        int n;
        int i;
        n = int'(cfg_length);
        if (n > lsm_pkg::PAT_BYTES)
            n = lsm_pkg::PAT_BYTES;
        if (n > MAX_PATTERN)
            n = MAX_PATTERN;
        for (i = 0; i < n; i++)
            if (cfg_pattern[i] == lsm_pkg::CHAR_NUL)
                return i;
        return n;
    endfunction

    // Advance the line state by one byte; return 1 with the result at a line end
    function automatic bit predict_line_result(input logic [lsm_pkg::BYTE_W-1:0] b,
                                               input logic last,
                                               output line_result_t res);
        int  span;
        int  i;
        bit  hit;
        bit  chosen;
        res = '0;
        if (!zero_seen)
        begin
            if (b == lsm_pkg::CHAR_NUL)
                zero_seen = 1'b1;
            else
            begin
                for (i = lsm_pkg::PAT_BYTES - 1; i > 0; i--)
                    window_bytes[i] = window_bytes[i-1];
                window_bytes[0] = b;
                span = pattern_span();
                if (bytes_in_line + 1 >= span)
                begin
                    hit = 1'b1;
                    for (i = 0; i < span; i++)
                        if (lower_ascii(window_bytes[span-1-i]) != lower_ascii(cfg_pattern[i]))
                            hit = 1'b0;
                    if (hit)
                        pattern_found = 1'b1;
                end
            end
        end
        bytes_in_line++;
        if (!(b == lsm_pkg::CHAR_NEWLINE || last || bytes_in_line >= LINE_LIMIT))
            return 1'b0;

        chosen = pattern_found ^ cfg_invert;
        if (lines_counted != '1)
            lines_counted++;
        if (chosen && lines_chosen != '1)
            lines_chosen++;
        res.selected = chosen;
        res.line_no  = lines_counted;
        res.total    = lines_chosen;

        // Clear the line state
        for (i = 0; i < lsm_pkg::PAT_BYTES; i++)
            window_bytes[i] = '0;
        bytes_in_line = 0;
        pattern_found = 1'b0;
        zero_seen     = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [lsm_pkg::COUNT_W-1:0] got,
                                   input logic [lsm_pkg::COUNT_W-1:0] want);
        mismatch_count++;
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Predict on accepted bytes, check accepted results
    always @(posedge clk)
    begin : line_monitor
        line_result_t predicted;
        line_result_t want;
        if (rst_n)
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                if (predict_line_result(text_ch.text_byte, text_ch.file_last, predicted))
                begin
                    if (typed_valid)
                        predicted = typed_line;
                    pending_line_results.push_back(predicted);
                end
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_line_results.size() == 0)
                    report_mismatch("unexpected result, line_count", result_ch.line_count,
                                    '0);
                else
                begin
                    want = pending_line_results.pop_front();
                    if (result_ch.line_selected !== want.selected)
                        report_mismatch("line_selected", 32'(result_ch.line_selected),
                                        32'(want.selected));
                    if (result_ch.line_count !== want.line_no)
                        report_mismatch("line_count", result_ch.line_count, want.line_no);
                    if (result_ch.selected_total !== want.total)
                        report_mismatch("selected_total", result_ch.selected_total,
                                        want.total);
                end
            end
        end
    end

    // Drive one byte, opening a gap first when the burst has run out and gaps are on
    task automatic send_byte(input logic [lsm_pkg::BYTE_W-1:0] b, input logic last,
                             input bit typed, input line_result_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 6);
                text_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.file_last <= last;
        typed_valid       <= typed;
        typed_line        <= want;
        do
            @(posedge clk);
        while (!text_ch.ready);
        items_sent++;
    endtask

    // Hold input until every expected result is in, then let the pipe settle
    task automatic wait_drained();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_line_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [lsm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [lsm_pkg::CFG_W-1:0] data);
        write_enable <= 1'b1;
        reg_index    <= idx;
        write_data   <= data;
        @(posedge clk);
        case (idx)
            lsm_pkg::REG_PATTERN_LOW:    cfg_pattern[7:0]  = data;
            lsm_pkg::REG_PATTERN_HIGH:   cfg_pattern[15:8] = data;
            lsm_pkg::REG_PATTERN_LENGTH: cfg_length = data[lsm_pkg::LEN_W-1:0];
            lsm_pkg::REG_IGNORE_CASE:    cfg_fold   = data[0];
            lsm_pkg::REG_INVERT_RESULT:  cfg_invert = data[0];
            default: ;
        endcase
    endtask

    function automatic logic [lsm_pkg::BYTE_W-1:0] pick_letter();
        case ($urandom_range(0, 3))
            0: return 8'h61;
            1: return 8'h41;
            2: return 8'h62;
            default: return 8'h42;
        endcase
    endfunction

    // Bias text towards the letters that patterns are built from
    function automatic logic [lsm_pkg::BYTE_W-1:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 31);
        if (r == 0)
            return lsm_pkg::CHAR_NUL;
        if (r == 1)
            return lsm_pkg::CHAR_NEWLINE;
        if (r < 20)
            return pick_letter();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [lsm_pkg::BYTE_W-1:0] pick_pattern_byte();
        if ($urandom_range(0, 9) < 6)
            return pick_letter();
        return 8'($urandom_range(1, 255));
    endfunction

    // Load a fresh pattern setting: often short findable patterns, with
    // empty, clamped and zero-cut patterns mixed in
    task automatic configure_phase();
        logic [lsm_pkg::PAT_BYTES-1:0][lsm_pkg::BYTE_W-1:0] pat;
        logic [lsm_pkg::CFG_W-1:0]                          noise;
        int                                                 len;
        int                                                 mode;
        int                                                 i;
        for (i = 0; i < lsm_pkg::PAT_BYTES; i++)
            pat[i] = pick_pattern_byte();
        mode = $urandom_range(0, 9);
        case (mode)
            0, 1, 2, 3: len = $urandom_range(1, 4);
            4, 5:       len = $urandom_range(5, 16);
            6:          len = 16;
            7:          len = $urandom_range(17, 31);
            8:          len = 0;
            default:
            begin
                len = $urandom_range(1, 16);
                pat[$urandom_range(0, len - 1)] = lsm_pkg::CHAR_NUL;
            end
        endcase
        if ($urandom_range(0, 7) == 0)
            pat = {$urandom, $urandom, $urandom, $urandom};
        noise = {$urandom, $urandom};
        set_register(lsm_pkg::REG_PATTERN_LOW, pat[7:0]);
        set_register(lsm_pkg::REG_PATTERN_HIGH, pat[15:8]);
        set_register(lsm_pkg::REG_PATTERN_LENGTH,
                     {noise[lsm_pkg::CFG_W-1:lsm_pkg::LEN_W], lsm_pkg::LEN_W'(len)});
        noise = {$urandom, $urandom};
        set_register(lsm_pkg::REG_IGNORE_CASE,
                     {noise[lsm_pkg::CFG_W-1:1], 1'($urandom_range(0, 1))});
        noise = {$urandom, $urandom};
        set_register(lsm_pkg::REG_INVERT_RESULT,
                     {noise[lsm_pkg::CFG_W-1:1], 1'($urandom_range(0, 1))});
        write_enable <= 1'b0;
    endtask

    // Build one line of random text, often carrying the pattern, and send it
    task automatic send_line(input bit final_line, input int forced_len);
        logic [lsm_pkg::BYTE_W-1:0] line_bytes [$];
        logic [lsm_pkg::BYTE_W-1:0] c;
        int                         n;
        int                         at;
        int                         span;
        int                         k;
        bit                         long_line;
        if (forced_len >= 0)
            n = forced_len;
        else if ($urandom_range(0, 24) == 0)
            n = $urandom_range(200, 300);
        else
            n = $urandom_range(0, 20);
        long_line = (n >= LINE_LIMIT);
        for (k = 0; k < n; k++)
            line_bytes.push_back(pick_text_byte());

        // Insert the pattern, flipping letter case when folding is on
        span = int'(cfg_length) > lsm_pkg::PAT_BYTES ? lsm_pkg::PAT_BYTES : int'(cfg_length);
        if (span > 0 && $urandom_range(0, 9) < 5)
        begin
            at = $urandom_range(0, line_bytes.size());
            for (k = span - 1; k >= 0; k--)
            begin
                c = cfg_pattern[k];
                if (cfg_fold && $urandom_range(0, 1) &&
                    ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)))
                    c = c ^ lsm_pkg::CASE_OFFSET;
                line_bytes.insert(at, c);
            end
        end
        if (!long_line && $urandom_range(0, 9) < 8)
            line_bytes.push_back(lsm_pkg::CHAR_NEWLINE);
        if (final_line && line_bytes.size() == 0)
            line_bytes.push_back(pick_text_byte());

        for (k = 0; k < line_bytes.size(); k++)
            send_byte(line_bytes[k], final_line && (k == line_bytes.size() - 1), 1'b0, '0);
    endtask

    initial
    begin : stimulus
        stim_row_t    row;
        line_result_t want;
        int           r;
        int           lines;
        int           l;
        int           random_start;
        bit           first_phase;

        // Known values on every input from time zero
        rst_n              = 1'b0;
        write_enable       = 1'b0;
        reg_index          = lsm_pkg::REG_PATTERN_LOW;
        write_data         = '0;
        text_ch.valid      = 1'b0;
        text_ch.text_byte  = '0;
        text_ch.file_last  = 1'b0;
        result_ch.ready    = 1'b0;
        typed_valid        = 1'b0;
        typed_line         = '0;
        stall_mask         = 16'hFFFF;
        stall_step         = 0;
        cycle_count        = 0;
        mismatch_count     = 0;
        items_sent         = 0;
        burst_left         = 0;
        gaps_on            = 1'b1;
        cfg_pattern        = '0;
        cfg_length         = '0;
        cfg_fold           = 1'b0;
        cfg_invert         = 1'b0;
        for (r = 0; r < lsm_pkg::PAT_BYTES; r++)
            window_bytes[r] = '0;
        bytes_in_line      = 0;
        pattern_found      = 1'b0;
        zero_seen          = 1'b0;
        lines_counted      = '0;
        lines_chosen       = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (r = 0; r < DIRECTED_LEN; r++)
        begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_WRITE)
            begin
                if (r == 0 || DIRECTED_ROWS[r-1].kind != ROW_WRITE)
                    wait_drained();
                set_register(row.reg_idx, row.value);
                if (r == DIRECTED_LEN - 1 || DIRECTED_ROWS[r+1].kind != ROW_WRITE)
                    write_enable <= 1'b0;
            end
            else
            begin
                want = row.want;
                send_byte(row.value[lsm_pkg::BYTE_W-1:0], row.last, row.typed, want);
            end
        end

        // Random phases: fresh settings, then a run of lines ending the file
        random_start = items_sent;
        first_phase  = 1'b1;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            wait_drained();
            configure_phase();
            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = 0;
            lines      = $urandom_range(2, 8);
            for (l = 0; l < lines; l++)
            begin
                send_line(l == lines - 1, first_phase && l == 0 ? 300 : -1);
                // Pause now and then until the results have caught up
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
            first_phase = 1'b0;
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== line_substring_matcher_core.f =====
design/lsm_pkg.sv
design/lsm_if.sv
design/lsm_match.sv
design/line_substring_matcher_core.sv
dv/line_substring_matcher_core_test.sv
